FILE: src/bzf_pkg.sv
// ----------------------------------------------------------------------------
// bzf_pkg
// Shared types and constants for the quadratic Bezier flattener.
// ----------------------------------------------------------------------------
package bzf_pkg;

    localparam int SEGMENTS = 24;
    localparam int COORD_W  = 11;
    localparam int STEP_W   = 7;

    localparam int DIV      = SEGMENTS * SEGMENTS;
    localparam int W_W      = $clog2(DIV + 1);
    localparam int PROD_W   = COORD_W + W_W + 1;
    localparam int SUM_W    = PROD_W + 2;
    localparam int QM_W     = COORD_W + 1;

    // floor(2^SUM_W / DIV): quotient estimate is exact or one low
    localparam longint unsigned RECIP   = (64'd1 << SUM_W) / DIV;
    localparam int              RECIP_W = $clog2(RECIP + 1);
    localparam int              MUL_W   = SUM_W + RECIP_W;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic        [STEP_W-1:0]  t_step;
    typedef logic        [W_W-1:0]     t_weight;

    typedef struct packed {
        t_weight w0;
        t_weight w1;
        t_weight w2;
    } t_weights;

    function automatic t_weights weights_of(input t_step s);
        t_weight  rw;
        t_weight  sw;
        t_weights w;
        rw   = t_weight'(SEGMENTS - int'(s));
        sw   = t_weight'(s);
        w.w0 = rw * rw;
        w.w1 = t_weight'((rw * sw) << 1);
        w.w2 = sw * sw;
        return w;
    endfunction

endpackage

FILE: src/bzf_if.sv
// ----------------------------------------------------------------------------
// bzf_if
// Valid/ready channels of the Bezier flattener: curve in, segment out.
// ----------------------------------------------------------------------------
interface bzf_in_if;
    import bzf_pkg::*;

    logic   valid;
    logic   ready;
    t_coord start_x;
    t_coord start_y;
    t_coord ctrl_x;
    t_coord ctrl_y;
    t_coord end_x;
    t_coord end_y;

    modport source (output valid, start_x, start_y, ctrl_x, ctrl_y, end_x, end_y,
                    input ready);
    modport sink   (input valid, start_x, start_y, ctrl_x, ctrl_y, end_x, end_y,
                    output ready);
endinterface

interface bzf_out_if;
    import bzf_pkg::*;

    logic   valid;
    logic   ready;
    t_coord seg_from_x;
    t_coord seg_from_y;
    t_coord seg_to_x;
    t_coord seg_to_y;
    t_step  step_index;
    logic   last_segment;

    modport source (output valid, seg_from_x, seg_from_y, seg_to_x, seg_to_y,
                    step_index, last_segment, input ready);
    modport sink   (input valid, seg_from_x, seg_from_y, seg_to_x, seg_to_y,
                    step_index, last_segment, output ready);
endinterface

FILE: src/quadratic_bezier_flattener.sv
// ----------------------------------------------------------------------------
// quadratic_bezier_flattener
// Splits a quadratic Bezier curve into SEGMENTS line segments at uniform
// steps, each point computed exactly and truncated toward zero.
//
//   channel  dir  words per curve   contents
//   i_in     in   1                 start, control, end point
//   o_out    out  SEGMENTS          from point, to point, step, last flag
//
// One output word per cycle while o_out is not stalled, as the step
// sequencer issues one step per cycle unless stalled. The next curve is
// taken during the last step of the current one. Reset clears the
// sequencer and all stage valids. A stall on o_out freezes the whole
// pipeline; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module quadratic_bezier_flattener (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bzf_in_if.sink    i_in,
    bzf_out_if.source o_out
);
    import bzf_pkg::*;

    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic        [SUM_W-1:0]  t_mag;
    typedef logic        [QM_W-1:0]   t_qm;

    logic en;
    logic issue;
    logic seq_last;
    logic accept;

    // step sequencer
    logic   r_busy;
    t_step  r_step;
    t_coord r_sq_p0 [2];
    t_coord r_sq_c  [2];
    t_coord r_sq_p1 [2];

    // stage 1: weights
    logic     r_s1_vld;
    t_weights r_s1_w;
    t_coord   r_s1_p0 [2];
    t_coord   r_s1_c  [2];
    t_coord   r_s1_p1 [2];
    t_step    r_s1_step;
    logic     r_s1_last;

    // stage 2: products
    logic   r_s2_vld;
    t_prod  r_s2_m0 [2];
    t_prod  r_s2_m1 [2];
    t_prod  r_s2_m2 [2];
    t_coord r_s2_st [2];
    t_step  r_s2_step;
    logic   r_s2_last;

    // stage 3: sum, sign and magnitude
    logic   r_s3_vld;
    logic   r_s3_neg [2];
    t_mag   r_s3_mag [2];
    t_coord r_s3_st  [2];
    t_step  r_s3_step;
    logic   r_s3_last;

    // stage 4: reciprocal multiply
    logic   r_s4_vld;
    logic   r_s4_neg [2];
    t_mag   r_s4_mag [2];
    t_qm    r_s4_q   [2];
    t_coord r_s4_st  [2];
    t_step  r_s4_step;
    logic   r_s4_last;

    // stage 5: quotient correction
    logic   r_s5_vld;
    t_coord r_s5_pt [2];
    t_coord r_s5_st [2];
    t_step  r_s5_step;
    logic   r_s5_last;

    // output register
    logic   r_out_vld;
    t_coord r_out_from [2];
    t_coord r_out_to   [2];
    t_step  r_out_step;
    logic   r_out_last;
    t_coord r_prev     [2];

    t_weights n_w;
    t_prod    n_m0 [2];
    t_prod    n_m1 [2];
    t_prod    n_m2 [2];
    t_prod    n_sum_dummy;
    logic signed [SUM_W-1:0] n_sum [2];
    t_mag     n_mag [2];
    logic [MUL_W-1:0] n_mul [2];
    t_qm      n_q   [2];
    t_mag     n_rem [2];
    t_qm      n_qc  [2];
    t_coord   n_pt  [2];
    t_coord   n_from [2];

    assign en       = !r_out_vld || o_out.ready;
    assign issue    = en && r_busy;
    assign seq_last = (r_step == t_step'(SEGMENTS));
    assign i_in.ready = !r_busy || (issue && seq_last);
    assign accept   = i_in.valid && i_in.ready;

    assign n_w         = weights_of(r_step);
    assign n_sum_dummy = '0;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_m0[l] = t_prod'(r_s1_p0[l]) * t_prod'($signed({1'b0, r_s1_w.w0}));
            n_m1[l] = t_prod'(r_s1_c[l])  * t_prod'($signed({1'b0, r_s1_w.w1}));
            n_m2[l] = t_prod'(r_s1_p1[l]) * t_prod'($signed({1'b0, r_s1_w.w2}));

            n_sum[l] = SUM_W'(r_s2_m0[l]) + SUM_W'(r_s2_m1[l]) + SUM_W'(r_s2_m2[l])
                     + SUM_W'(n_sum_dummy);
            n_mag[l] = n_sum[l][SUM_W-1] ? t_mag'(-n_sum[l]) : t_mag'(n_sum[l]);

            n_mul[l] = MUL_W'(r_s3_mag[l]) * MUL_W'(RECIP);
            n_q[l]   = QM_W'(n_mul[l] >> SUM_W);

            n_rem[l] = r_s4_mag[l] - (t_mag'(r_s4_q[l]) * t_mag'(DIV));
            n_qc[l]  = (n_rem[l] >= t_mag'(DIV)) ? r_s4_q[l] + t_qm'(1) : r_s4_q[l];
            n_pt[l]  = r_s4_neg[l] ? COORD_W'(-n_qc[l]) : COORD_W'(n_qc[l]);

            n_from[l] = (r_s5_step == t_step'(1)) ? r_s5_st[l] : r_prev[l];
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_step    <= '0;
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s4_vld  <= 1'b0;
            r_s5_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
                r_step <= t_step'(1);
            end else if (issue && seq_last) begin
                r_busy <= 1'b0;
            end else if (issue) begin
                r_step <= r_step + t_step'(1);
            end
            if (en) begin
                r_s1_vld  <= r_busy;
                r_s2_vld  <= r_s1_vld;
                r_s3_vld  <= r_s2_vld;
                r_s4_vld  <= r_s3_vld;
                r_s5_vld  <= r_s4_vld;
                r_out_vld <= r_s5_vld;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sq_p0[0] <= i_in.start_x;
            r_sq_p0[1] <= i_in.start_y;
            r_sq_c[0]  <= i_in.ctrl_x;
            r_sq_c[1]  <= i_in.ctrl_y;
            r_sq_p1[0] <= i_in.end_x;
            r_sq_p1[1] <= i_in.end_y;
        end
        if (en) begin
            r_s1_w    <= n_w;
            r_s1_step <= r_step;
            r_s1_last <= seq_last;
            r_s2_step <= r_s1_step;
            r_s2_last <= r_s1_last;
            r_s3_step <= r_s2_step;
            r_s3_last <= r_s2_last;
            r_s4_step <= r_s3_step;
            r_s4_last <= r_s3_last;
            r_s5_step <= r_s4_step;
            r_s5_last <= r_s4_last;
            for (int l = 0; l < 2; l++) begin
                r_s1_p0[l]  <= r_sq_p0[l];
                r_s1_c[l]   <= r_sq_c[l];
                r_s1_p1[l]  <= r_sq_p1[l];
                r_s2_m0[l]  <= n_m0[l];
                r_s2_m1[l]  <= n_m1[l];
                r_s2_m2[l]  <= n_m2[l];
                r_s2_st[l]  <= r_s1_p0[l];
                r_s3_neg[l] <= n_sum[l][SUM_W-1];
                r_s3_mag[l] <= n_mag[l];
                r_s3_st[l]  <= r_s2_st[l];
                r_s4_neg[l] <= r_s3_neg[l];
                r_s4_mag[l] <= r_s3_mag[l];
                r_s4_q[l]   <= n_q[l];
                r_s4_st[l]  <= r_s3_st[l];
                r_s5_pt[l]  <= n_pt[l];
                r_s5_st[l]  <= r_s4_st[l];
            end
            if (r_s5_vld) begin
                r_out_step <= r_s5_step;
                r_out_last <= r_s5_last;
                for (int l = 0; l < 2; l++) begin
                    r_out_from[l] <= n_from[l];
                    r_out_to[l]   <= r_s5_pt[l];
                    r_prev[l]     <= r_s5_pt[l];
                end
            end
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.seg_from_x   = r_out_from[0];
    assign o_out.seg_from_y   = r_out_from[1];
    assign o_out.seg_to_x     = r_out_to[0];
    assign o_out.seg_to_y     = r_out_to[1];
    assign o_out.step_index   = r_out_step;
    assign o_out.last_segment = r_out_last;

endmodule
